// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// ASSERT_ALWAYS checks an expression at every rising clock edge out of reset.
// ASSERT_IMPLY checks that a condition implies a consequence in the same cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr)

`define ASSERT_IMPLY(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/ebcf_pkg.sv =====
`timescale 1ns / 1ps

package ebcf_pkg;

    // Fixed point of the eased ratio
    localparam int FRAC_BITS = 16;
    localparam int RATIO_W   = FRAC_BITS + 1;
    localparam logic [RATIO_W-1:0] ONE_Q  = RATIO_W'(1) << FRAC_BITS;
    localparam logic [RATIO_W-1:0] HALF_Q = ONE_Q >> 1;

    // Field widths
    localparam int DUR_W   = 16;
    localparam int STAMP_W = 32;
    localparam int COLOR_W = 8;
    localparam int NUM_CH  = 3;
    localparam int Q16_W   = 17;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

    // Command queue, depth must be a power of two
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DURATION = 8'd0,
        CFG_RED      = 8'd1,
        CFG_GREEN    = 8'd2,
        CFG_BLUE     = 8'd3
    } cfg_idx_t;

    localparam logic [DUR_W-1:0]   DUR_RESET   = 16'd500;
    localparam logic [COLOR_W-1:0] RED_RESET   = 8'd255;
    localparam logic [COLOR_W-1:0] GREEN_RESET = 8'd0;
    localparam logic [COLOR_W-1:0] BLUE_RESET  = 8'd0;

    // Slave tdata layout
    localparam int S_TDATA_W  = 64;
    localparam int S_OFS_NOW  = 0;
    localparam int S_OFS_BRK  = S_OFS_NOW + STAMP_W;
    localparam int S_OFS_BACK = S_OFS_BRK + 1;

    // Master tdata layout
    localparam int M_TDATA_W   = 48;
    localparam int M_OFS_CHG   = 0;
    localparam int M_OFS_RATIO = 1;
    localparam int M_OFS_ACT   = M_OFS_RATIO + Q16_W;
    localparam int M_OFS_RGB   = M_OFS_ACT + 1;

    // Q16 output conversion shifts
    localparam int Q16_RSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int Q16_LSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int WIDE_W  = RATIO_W + 16;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    // Index 0 red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][COLOR_W-1:0] rgb_t;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        rgb_t             target;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic             changed;
        logic [DUR_W-1:0] ramp;
        rgb_t             back;
    } cmd_t;

    function automatic logic [Q16_W-1:0] to_q16(input logic [RATIO_W-1:0] r);
        logic [WIDE_W-1:0] w;
        w = (WIDE_W'(r) >> Q16_RSH) << Q16_LSH;
        return w[Q16_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ebcf_front.sv =====
`timescale 1ns / 1ps

module ebcf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ebcf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  ebcf_pkg::cfg_t                      cfg,
    input  logic                                fifo_full,
    output logic                                fifo_push,
    output ebcf_pkg::cmd_t                      fifo_cmd
);

    localparam int DW = ebcf_pkg::DUR_W;
    localparam int SW = ebcf_pkg::STAMP_W;

    logic [SW-1:0] last_stamp_reg, last_stamp_next;
    logic [DW-1:0] ramp_reg, ramp_next;
    logic [SW-1:0] now_ms;
    logic          brake_on;
    logic [SW-1:0] delta;
    logic [SW:0]   sum;
    logic          changed;

    // No beat is taken while reset is held
    assign s_tready  = aresetn && !fifo_full;
    assign fifo_push = s_tvalid && s_tready;

    // Tick: move the ramp by the wrapped time step, up toward the duration while braking, down toward zero otherwise
    always_comb begin
        now_ms          = s_tdata[ebcf_pkg::S_OFS_NOW +: SW];
        brake_on        = s_tdata[ebcf_pkg::S_OFS_BRK];
        delta           = now_ms - last_stamp_reg;
        sum             = (SW + 1)'(ramp_reg) + (SW + 1)'(delta);
        ramp_next       = ramp_reg;
        last_stamp_next = last_stamp_reg;
        changed         = 1'b0;
        if (ebcf_pkg::op_t'(s_tuser) == ebcf_pkg::OP_TICK) begin
            last_stamp_next = now_ms;
            if (brake_on) begin
                if (ramp_reg != cfg.duration) begin
                    changed = 1'b1;
                    if (sum > (SW + 1)'(cfg.duration)) begin
                        ramp_next = cfg.duration;
                    end else begin
                        ramp_next = sum[DW-1:0];
                    end
                end
            end else if (ramp_reg != '0) begin
                changed = 1'b1;
                if (SW'(ramp_reg) > delta) begin
                    ramp_next = ramp_reg - delta[DW-1:0];
                end else begin
                    ramp_next = '0;
                end
            end
        end
    end

    // Command handed to the back end
    always_comb begin
        fifo_cmd.op      = ebcf_pkg::op_t'(s_tuser);
        fifo_cmd.changed = changed;
        fifo_cmd.ramp    = ramp_next;
        fifo_cmd.back    = s_tdata[ebcf_pkg::S_OFS_BACK +: $bits(ebcf_pkg::rgb_t)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stamp_reg <= '0;
            ramp_reg       <= '0;
        end else if (fifo_push) begin
            last_stamp_reg <= last_stamp_next;
            ramp_reg       <= ramp_next;
        end
    end

endmodule

// ===== rtl/core/ebcf_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ebcf_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ebcf_pkg::cmd_t  cmd_in,
    output logic            full,
    input  logic            pop,
    output ebcf_pkg::cmd_t  cmd_out,
    output logic            empty
);

    localparam int DEPTH = ebcf_pkg::FIFO_DEPTH;
    localparam int PW    = ebcf_pkg::FIFO_PTR_W;
    localparam int CW    = ebcf_pkg::FIFO_CNT_W;

    ebcf_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_fifo_level, aclk, aresetn, count_reg <= CW'(DEPTH))
    `ASSERT_IMPLY(a_fifo_no_overrun, aclk, aresetn, full, !push)
    `ASSERT_IMPLY(a_fifo_no_underrun, aclk, aresetn, empty, !pop)

endmodule

// ===== rtl/core/ebcf_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ebcf_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ebcf_pkg::cfg_t                     cfg,
    input  logic                               fifo_empty,
    input  ebcf_pkg::cmd_t                     fifo_cmd,
    output logic                               fifo_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ebcf_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int F   = ebcf_pkg::FRAC_BITS;
    localparam int RW  = ebcf_pkg::RATIO_W;
    localparam int DW  = ebcf_pkg::DUR_W;
    localparam int CW  = ebcf_pkg::COLOR_W;
    localparam int NCH = ebcf_pkg::NUM_CH;
    localparam int PRW = 2 * F;
    localparam int PXW = RW + CW;
    localparam int KW  = ebcf_pkg::DIV_CNT_W;
    localparam int MW  = ebcf_pkg::M_TDATA_W;
    localparam int QW  = ebcf_pkg::Q16_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EASE,
        ST_SQ,
        ST_CUBE,
        ST_FIN,
        ST_PIX,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    ebcf_pkg::cmd_t          cmd_reg;
    logic [RW-1:0]           eased_ratio_reg;
    logic [DW-1:0]           rem_reg;
    logic [RW-1:0]           x_reg;
    logic [KW-1:0]           cnt_reg;
    logic [F-1:0]            t_reg;
    logic                    lower_reg;
    logic [PRW-1:0]          prod_reg;
    logic [NCH-1:0][PXW-1:0] pix_prod_reg;
    logic [NCH-1:0]          neg_reg;
    logic                    m_tvalid_reg;
    logic [MW-1:0]           m_tdata_reg;

    logic [DW:0]             rem2;
    logic                    quo_bit;
    logic [DW-1:0]           rem_next;
    logic [RW-1:0]           ease_mirror;
    logic                    half;
    logic [F-1:0]            t_val;
    logic [F+1:0]            e_wide;
    logic [RW-1:0]           e_val;
    logic [RW-1:0]           ease_val;
    logic [NCH-1:0][CW-1:0]  mag;
    logic [NCH-1:0]          neg;
    logic [PXW:0]            psum;
    logic [PXW-F:0]          part;
    ebcf_pkg::rgb_t          color;
    logic [MW-1:0]           out_word;
    logic                    emit_load;

    assign fifo_pop = (state_reg == ST_IDLE) && !fifo_empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Output register can take a new beat
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Restoring divider step, one quotient bit per cycle
    always_comb begin
        rem2    = {rem_reg, 1'b0};
        quo_bit = (rem2 >= (DW + 1)'(cfg.duration));
        if (quo_bit) begin
            rem_next = DW'(rem2 - (DW + 1)'(cfg.duration));
        end else begin
            rem_next = rem2[DW-1:0];
        end
    end

    // Ease-in-out cubic: fold the upper half onto the lower half
    always_comb begin
        ease_mirror = ebcf_pkg::ONE_Q - x_reg;
        half        = (x_reg < ebcf_pkg::HALF_Q);
        t_val       = half ? x_reg[F-1:0] : ease_mirror[F-1:0];
        e_wide      = prod_reg[PRW-1:F-2];
        e_val       = e_wide[RW-1:0];
        ease_val    = lower_reg ? e_val : (ebcf_pkg::ONE_Q - e_val);
    end

    // Channel differences toward the target color
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            neg[i] = (cmd_reg.back[i] > cfg.target[i]);
            mag[i] = neg[i] ? (cmd_reg.back[i] - cfg.target[i])
                            : (cfg.target[i] - cmd_reg.back[i]);
        end
    end

    // Blend: floor going up, ceiling of the step going down
    always_comb begin
        psum  = '0;
        part  = '0;
        color = '0;
        for (int i = 0; i < NCH; i++) begin
            if (neg_reg[i]) begin
                psum     = (PXW + 1)'(pix_prod_reg[i]) + (PXW + 1)'(ebcf_pkg::ONE_Q - 1'b1);
                part     = psum[PXW:F];
                color[i] = cmd_reg.back[i] - part[CW-1:0];
            end else begin
                psum     = (PXW + 1)'(pix_prod_reg[i]);
                part     = psum[PXW:F];
                color[i] = cmd_reg.back[i] + part[CW-1:0];
            end
        end
    end

    // Result beat
    always_comb begin
        out_word = '0;
        out_word[ebcf_pkg::M_OFS_CHG] =
            (cmd_reg.op == ebcf_pkg::OP_TICK) && cmd_reg.changed;
        out_word[ebcf_pkg::M_OFS_RATIO +: QW] = ebcf_pkg::to_q16(eased_ratio_reg);
        out_word[ebcf_pkg::M_OFS_ACT] = (eased_ratio_reg != '0);
        if (cmd_reg.op == ebcf_pkg::OP_PIXEL) begin
            out_word[ebcf_pkg::M_OFS_RGB +: $bits(ebcf_pkg::rgb_t)] = color;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            eased_ratio_reg <= '0;
        end else begin
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!fifo_empty) begin
                        cmd_reg <= fifo_cmd;
                        if (fifo_cmd.op == ebcf_pkg::OP_PIXEL) begin
                            state_reg <= ST_PIX;
                        end else if (!fifo_cmd.changed) begin
                            state_reg <= ST_EMIT;
                        end else if (cfg.duration == '0) begin
                            eased_ratio_reg <= '0;
                            state_reg       <= ST_EMIT;
                        end else if (fifo_cmd.ramp >= cfg.duration) begin
                            x_reg     <= ebcf_pkg::ONE_Q;
                            state_reg <= ST_EASE;
                        end else begin
                            rem_reg   <= fifo_cmd.ramp;
                            x_reg     <= '0;
                            cnt_reg   <= KW'(F);
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    x_reg   <= {x_reg[RW-2:0], quo_bit};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == KW'(1)) begin
                        state_reg <= ST_EASE;
                    end
                end
                ST_EASE: begin
                    t_reg     <= t_val;
                    lower_reg <= half;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    prod_reg  <= PRW'(t_reg) * PRW'(t_reg);
                    state_reg <= ST_CUBE;
                end
                ST_CUBE: begin
                    prod_reg  <= PRW'(prod_reg[PRW-1:F]) * PRW'(t_reg);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    eased_ratio_reg <= ease_val;
                    state_reg       <= ST_EMIT;
                end
                ST_PIX: begin
                    for (int i = 0; i < NCH; i++) begin
                        pix_prod_reg[i] <= PXW'(eased_ratio_reg) * PXW'(mag[i]);
                    end
                    neg_reg   <= neg;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        m_tdata_reg <= out_word;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_ratio_range, aclk, aresetn, eased_ratio_reg <= ebcf_pkg::ONE_Q)
    `ASSERT_IMPLY(a_div_count, aclk, aresetn, state_reg == ST_DIV, cnt_reg != '0)
    `ASSERT_IMPLY(a_beat_from_emit, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == ST_EMIT)

endmodule

// ===== rtl/core/eased_brake_color_fade_top.sv =====
// Brake-light color crossfade. Each input beat is either a tick (s_tuser = 0) carrying a
// millisecond timestamp and the brake flag, or a pixel request (s_tuser = 1) carrying a
// background RGB. Ticks ramp an internal fade time toward the configured duration while the
// brake is on and back toward zero while it is off; whenever that time moves, the eased
// (cubic in-out) Q16 ratio is recomputed. Pixel requests blend the background toward the
// target color by the current ratio. Every input beat yields exactly one output beat, in
// order. A front end takes beats into a two-entry command queue, so with one result waiting
// at the output and the next one held in the back end, two more beats are still accepted.
// A tick that moves the ratio occupies the back end through the bit-serial restoring
// divider, then the fold, two 16x16 multiplications and the final ease step; once the
// ramp has reached the duration the divider is skipped. A tick that leaves the ratio alone
// goes straight to the output register, and a pixel request first has its channel products
// registered. Configuration registers (index 0 duration, 1 red, 2 green, 3 blue; others
// ignored) are written through the cfg channel, which is ready whenever reset is released,
// and should only be written while the block is idle.
`timescale 1ns / 1ps

module eased_brake_color_fade_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // cfg channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ebcf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ebcf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // now_ms[31:0], brake_on[32], back_red[40:33], back_green[48:41],
    // back_blue[56:49], zero pad[63:57]
    input  logic [ebcf_pkg::S_TDATA_W-1:0]       s_tdata,
    // op[0]: 0 tick, 1 pixel
    input  logic                                 s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // ratio_changed[0], blend_ratio[17:1], layer_active[18], out_red[26:19],
    // out_green[34:27], out_blue[42:35], zero pad[47:43]
    output logic [ebcf_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int CW = ebcf_pkg::COLOR_W;
    localparam int DW = ebcf_pkg::DUR_W;

    ebcf_pkg::cfg_t cfg_reg;
    ebcf_pkg::cmd_t push_cmd;
    ebcf_pkg::cmd_t pop_cmd;
    logic           fifo_push;
    logic           fifo_pop;
    logic           fifo_full;
    logic           fifo_empty;

    assign cfg_ready = aresetn;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duration  <= ebcf_pkg::DUR_RESET;
            cfg_reg.target[0] <= ebcf_pkg::RED_RESET;
            cfg_reg.target[1] <= ebcf_pkg::GREEN_RESET;
            cfg_reg.target[2] <= ebcf_pkg::BLUE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                ebcf_pkg::CFG_DURATION: cfg_reg.duration  <= cfg_wdata[DW-1:0];
                ebcf_pkg::CFG_RED:      cfg_reg.target[0] <= cfg_wdata[CW-1:0];
                ebcf_pkg::CFG_GREEN:    cfg_reg.target[1] <= cfg_wdata[CW-1:0];
                ebcf_pkg::CFG_BLUE:     cfg_reg.target[2] <= cfg_wdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    ebcf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg_reg),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_cmd  (push_cmd)
    );

    ebcf_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .cmd_in  (push_cmd),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .cmd_out (pop_cmd),
        .empty   (fifo_empty)
    );

    ebcf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_cmd   (pop_cmd),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== sim/tb_eased_brake_color_fade_top.sv =====
`timescale 1ns / 1ps

import ebcf_pkg::*;

// One input beat as the sender sees it
typedef struct {
    op_t                op;
    logic [STAMP_W-1:0] now;
    logic               brake;
    rgb_t               back;
} fade_in_t;

// One result beat, unpacked
typedef struct {
    logic             changed;
    logic [Q16_W-1:0] ratio;
    logic             active;
    rgb_t             rgb;
} fade_out_t;

// Tracks fade state and the outstanding results, checks each result beat
class fade_checker;
    // Register copies
    bit [DUR_W-1:0]   fade_len;
    rgb_t             tint;
    // Fade state
    bit [STAMP_W-1:0] prev_stamp;
    bit [DUR_W-1:0]   ramp;
    bit [63:0]        eased;

    fade_out_t pending_fades[$];

    int errors;
    int n_ticks;
    int n_moves;
    int n_pixels;
    int n_checked;
    int n_writes;

    function new();
        fade_len   = DUR_RESET;
        tint[0]    = RED_RESET;
        tint[1]    = GREEN_RESET;
        tint[2]    = BLUE_RESET;
        prev_stamp = '0;
        ramp       = '0;
        eased      = '0;
        errors     = 0;
        n_ticks    = 0;
        n_moves    = 0;
        n_pixels   = 0;
        n_checked  = 0;
        n_writes   = 0;
    endfunction

    function int pending();
        return pending_fades.size();
    endfunction

    // Unmapped indexes are dropped, data is cut to the register width
    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        n_writes++;
        case (idx)
            CFG_DURATION: fade_len = val;
            CFG_RED:      tint[0]  = val[COLOR_W-1:0];
            CFG_GREEN:    tint[1]  = val[COLOR_W-1:0];
            CFG_BLUE:     tint[2]  = val[COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    // Cubic in-out of ramp / duration, FRAC_BITS fraction bits
    function bit [63:0] ease_from_ramp();
        bit [63:0] one;
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] sq;
        one = 64'd1 << FRAC_BITS;
        if (fade_len == 0) begin
            return 64'd0;
        end
        x = (64'(ramp) << FRAC_BITS) / 64'(fade_len);
        if (x > one) begin
            x = one;
        end
        if (x < one / 2) begin
            sq = (x * x) >> FRAC_BITS;
            return (64'd4 * sq * x) >> FRAC_BITS;
        end
        y  = one - x;
        sq = (y * y) >> FRAC_BITS;
        return one - ((64'd4 * sq * y) >> FRAC_BITS);
    endfunction

    // floor(back + eased * (tgt - back) / ONE)
    function bit [COLOR_W-1:0] mix(bit [COLOR_W-1:0] back, bit [COLOR_W-1:0] tgt);
        bit [63:0] one;
        bit [63:0] d;
        one = 64'd1 << FRAC_BITS;
        if (tgt >= back) begin
            d = 64'(tgt) - 64'(back);
            return COLOR_W'(64'(back) + ((eased * d) >> FRAC_BITS));
        end
        d = 64'(back) - 64'(tgt);
        return COLOR_W'(64'(back) - ((eased * d + one - 64'd1) >> FRAC_BITS));
    endfunction

    function bit [Q16_W-1:0] ratio_q16();
        int rsh;
        int lsh;
        rsh = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
        lsh = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
        return Q16_W'((eased >> rsh) << lsh);
    endfunction

    // Advance the fade for one accepted input beat and queue its result
    function void take_item(fade_in_t it);
        fade_out_t        want;
        bit [STAMP_W-1:0] d32;
        bit [63:0]        delta;
        bit [63:0]        sum;
        want.changed = 1'b0;
        want.rgb     = '0;
        if (it.op == OP_TICK) begin
            n_ticks++;
            d32        = it.now - prev_stamp;
            delta      = 64'(d32);
            prev_stamp = it.now;
            if (it.brake) begin
                if (ramp != fade_len) begin
                    sum          = 64'(ramp) + delta;
                    ramp         = (sum > 64'(fade_len)) ? fade_len : DUR_W'(sum);
                    want.changed = 1'b1;
                end
            end else if (ramp != 0) begin
                ramp         = (64'(ramp) > delta) ? DUR_W'(64'(ramp) - delta) : '0;
                want.changed = 1'b1;
            end
            if (want.changed) begin
                eased = ease_from_ramp();
                n_moves++;
            end
        end else begin
            n_pixels++;
            for (int c = 0; c < NUM_CH; c++) begin
                want.rgb[c] = mix(it.back[c], tint[c]);
            end
        end
        want.ratio  = ratio_q16();
        want.active = (eased != 0);
        pending_fades.push_back(want);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        $display("%0t ns: mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 $time, what, n_checked, got, want);
    endtask

    task check_beat(logic [M_TDATA_W-1:0] beat);
        fade_out_t want;
        fade_out_t got;
        got.changed = beat[M_OFS_CHG];
        got.ratio   = beat[M_OFS_RATIO +: Q16_W];
        got.active  = beat[M_OFS_ACT];
        got.rgb     = beat[M_OFS_RGB +: NUM_CH * COLOR_W];
        if (pending_fades.size() == 0) begin
            report_mismatch("unexpected result beat", beat, 0);
        end else begin
            want = pending_fades.pop_front();
            if (got.changed !== want.changed)
                report_mismatch("ratio_changed", got.changed, want.changed);
            if (got.ratio !== want.ratio)
                report_mismatch("blend_ratio", got.ratio, want.ratio);
            if (got.active !== want.active)
                report_mismatch("layer_active", got.active, want.active);
            if (got.rgb[0] !== want.rgb[0])
                report_mismatch("out_red", got.rgb[0], want.rgb[0]);
            if (got.rgb[1] !== want.rgb[1])
                report_mismatch("out_green", got.rgb[1], want.rgb[1]);
            if (got.rgb[2] !== want.rgb[2])
                report_mismatch("out_blue", got.rgb[2], want.rgb[2]);
        end
        n_checked++;
    endtask

    task finish_check();
        if (pending_fades.size() != 0) begin
            report_mismatch("results never delivered", pending_fades.size(), 0);
        end
    endtask
endclass

module tb_eased_brake_color_fade_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * (FRAC_BITS + 6);
    localparam logic [CFG_ADDR_W-1:0] IDX_UNMAPPED = 8'd7;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    fade_checker sb = new();

    // Stimulus knobs
    int               tx_gap_pct   = 25;
    int               rx_stall_pct = 25;
    int               rx_stall_cnt = 0;
    int               quiet_cycles = 0;
    bit [DUR_W-1:0]   fade_len     = DUR_RESET;
    bit [STAMP_W-1:0] stamp_cursor = '0;
    bit               brake_now    = 1'b0;
    int               brake_left   = 0;

    eased_brake_color_fade_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_stall_cnt <= 0;
        end else if (rx_stall_cnt != 0) begin
            m_tready     <= 1'b0;
            rx_stall_cnt <= rx_stall_cnt - 1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            m_tready     <= 1'b0;
            rx_stall_cnt <= $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata);
        end
    end

    // Watchdog: cycles without any accepted beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Random gap first, then hold the beat until it is taken
    task automatic send_item(input fade_in_t it);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= S_TDATA_W'({it.back, it.brake, it.now});
        do @(posedge aclk); while (!s_tready);
        sb.take_item(it);
    endtask

    // Stop sending and let every outstanding result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic fade_in_t tick_item(input logic [STAMP_W-1:0] now, input logic brake);
        fade_in_t it;
        it.op    = OP_TICK;
        it.now   = now;
        it.brake = brake;
        it.back  = 24'($urandom);
        return it;
    endfunction

    function automatic fade_in_t pixel_item(input logic [COLOR_W-1:0] r,
                                            input logic [COLOR_W-1:0] g,
                                            input logic [COLOR_W-1:0] b);
        fade_in_t it;
        it.op      = OP_PIXEL;
        it.now     = $urandom;
        it.brake   = 1'($urandom_range(0, 1));
        it.back[0] = r;
        it.back[1] = g;
        it.back[2] = b;
        return it;
    endfunction

    // Mostly plausible brake runs with small time steps, some pixels, some noise jumps
    task automatic next_item(output fade_in_t it);
        int pick;
        pick     = $urandom_range(0, 99);
        it.now   = $urandom;
        it.brake = 1'($urandom_range(0, 1));
        it.back  = 24'($urandom);
        if (pick < 45) begin
            it.op = OP_PIXEL;
        end else begin
            it.op = OP_TICK;
            if (pick < 90) begin
                if (brake_left == 0) begin
                    brake_now  = !brake_now;
                    brake_left = $urandom_range(2, 30);
                end
                brake_left--;
                stamp_cursor += $urandom_range(0, fade_len / 8 + 1);
                it.now   = stamp_cursor;
                it.brake = brake_now;
            end else begin
                stamp_cursor = it.now;
            end
        end
    endtask

    task automatic run_phase(input logic [DUR_W-1:0] dur, input logic [COLOR_W-1:0] r,
                             input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
                             input int n, input int gap_pct, input int stall_pct);
        fade_in_t it;
        wait_idle();
        write_reg(CFG_DURATION, dur);
        write_reg(CFG_RED, {8'($urandom), r});
        write_reg(CFG_GREEN, {8'($urandom), g});
        write_reg(CFG_BLUE, {8'($urandom), b});
        cfg_valid    <= 1'b0;
        fade_len     = dur;
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        repeat (n) begin
            next_item(it);
            send_item(it);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset colors, duration 500
        send_item(pixel_item(8'd0, 8'd0, 8'd0));          // zero ratio passes background
        send_item(tick_item(32'd0, 1'b0));                // already at zero, no change
        send_item(tick_item(32'd0, 1'b1));                // zero delta still recomputes
        send_item(tick_item(32'd125, 1'b1));              // lower half of the curve
        send_item(pixel_item(8'd255, 8'd255, 8'd255));    // negative diffs round down
        send_item(tick_item(32'd300, 1'b1));              // upper half of the curve
        send_item(tick_item(32'd1000, 1'b1));             // overshoot clamps to duration
        send_item(tick_item(32'd1001, 1'b1));             // at duration, no change
        send_item(pixel_item(8'd0, 8'd128, 8'd255));      // full target color

        // Duration cut below the current ramp: ratio must clamp to one
        wait_idle();
        write_reg(CFG_DURATION, 16'd100);
        cfg_valid <= 1'b0;
        fade_len  = 16'd100;
        send_item(tick_item(32'd1002, 1'b0));
        send_item(tick_item(32'd1100, 1'b0));
        send_item(tick_item(32'hFFFF_FFF0, 1'b0));        // huge delta empties the ramp
        send_item(tick_item(32'h0000_0010, 1'b1));        // timestamp wraps, small delta
        send_item(tick_item(32'hFFFF_FFFF, 1'b1));        // wide sum, no wrap
        send_item(pixel_item(8'd255, 8'd0, 8'd128));

        // Wide data gets masked, unmapped index is dropped
        wait_idle();
        write_reg(CFG_GREEN, 16'hA55A);
        write_reg(IDX_UNMAPPED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_item(tick_item(32'h0000_0020, 1'b0));
        send_item(pixel_item(8'h80, 8'h80, 8'h80));
        send_item(pixel_item(8'd0, 8'd255, 8'd0));
        stamp_cursor = 32'h0000_0020;

        // Random phases over several register settings
        run_phase(16'd1, 8'd0, 8'd255, 8'd0, 200, 20, 20);
        run_phase(16'd65535, 8'd255, 8'd0, 8'd255, 200, 0, 0);
        run_phase(16'($urandom_range(1, 2000)), 8'($urandom), 8'($urandom), 8'($urandom),
                  200, 40, 40);
        run_phase(16'($urandom_range(1, 65535)), 8'($urandom), 8'($urandom), 8'($urandom),
                  200, 10, 60);
        run_phase(DUR_RESET, RED_RESET, GREEN_RESET, BLUE_RESET, 220, 0, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.finish_check();

        $display("Run covered %0d ticks (%0d moved the fade) and %0d pixel blends,",
                 sb.n_ticks, sb.n_moves, sb.n_pixels);
        $display("%0d register writes, %0d results checked, %0d mismatches.",
                 sb.n_writes, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ebcf_pkg.sv
rtl/core/ebcf_front.sv
rtl/core/ebcf_fifo.sv
rtl/core/ebcf_back.sv
rtl/core/eased_brake_color_fade_top.sv
sim/tb_eased_brake_color_fade_top.sv
